// ===== rtl/core/cas_pkg.sv =====
`timescale 1ns / 1ps

package cas_pkg;

    // Largest grid side the line stores are sized for.
    localparam int DEFAULT_MAX_SIDE = 128;

    // Configuration register indexes.
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_GRID_SIZE   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DEATH_LIMIT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BIRTH_LIMIT = 2'd2;

    localparam int GRID_W  = 8;
    localparam int LIMIT_W = 4;

    localparam logic [GRID_W-1:0]  GRID_SIZE_RST   = 8'd91;
    localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd4;
    localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd4;

    // Up to three results per input cell; result queue sizing.
    localparam int MAX_RESULTS = 3;
    localparam int PUSH_W      = 2;
    localparam int RES_DEPTH   = 8;

    // Effective side minus one: grid_size clamped to [3, max_side].
    function automatic int side_m1_of(input logic [GRID_W-1:0] gs, input int max_side);
        int n;
        n = int'(gs);
        if (n < 3) n = 3;
        if (n > max_side) n = max_side;
        return n - 1;
    endfunction

endpackage

// ===== rtl/core/cas_out_fifo.sv =====
`timescale 1ns / 1ps

// Result queue: takes up to MAX_RESULTS entries per cycle, hands out one unless stalled.
module cas_out_fifo
    import cas_pkg::*;
#(
    parameter int W     = 16,
    parameter int DEPTH = RES_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [PUSH_W-1:0]                 push_n,
    input  logic [MAX_RESULTS-1:0][W-1:0]     push_data,
    output logic                              room,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [W-1:0]                      out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNTW = PW + 1;
    localparam int ROOM_MAX = DEPTH - 2 * MAX_RESULTS;

    logic [W-1:0]    mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    // Room for the cell in flight plus one more, each at full fan-out.
    assign room      = (count_reg <= CNTW'(ROOM_MAX));

    assign count_next = count_reg + CNTW'(push_n) - CNTW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (PUSH_W'(k) < push_n)
            begin
                mem_reg[wr_ptr_reg + PW'(k)] <= push_data[k];
            end
        end
    end

endmodule

// ===== rtl/core/cave_automaton_smoothing_pass.sv =====
`timescale 1ns / 1ps

// Cave smoothing pass: one cellular-automaton step over a square binary grid.
//
// Input channel (in_valid / in_stall / cell_alive): one cell per transaction,
// raster order, row 0 column 0 first. Output channel (out_valid / out_stall):
// one smoothed cell per transaction with its out_row / out_col; frame_done
// marks the last cell of the grid, after which the next pass starts.
// Configuration: cfg_we / cfg_index / cfg_data, written only while idle.
// Writing grid_size restarts the pass; limits apply at once.
//
// Pipeline: accept edge -> line store read -> window update and decision in
// the next cycle -> result queue -> out port. A result is pushed into the
// queue at the edge after the accept of the input cell that completes its
// window, and is offered on the output once the results ahead of it are out
// (cell (r,c) is completed by (r+1,c+1); right-column cells by the cell
// below them; bottom-row cells by themselves).
// Throughput: one input cell per cycle. Each cell yields one result on
// average, two at a row end below row 0 and in the last row past column 0,
// three at the last row's end; the single output port (one result per cycle)
// sets the sustained rate there, and in_stall rises when the queue fills up.
// Line stores: one 2-bit wide synchronous memory, read at the accept edge,
// written back at the next edge. Same-column accesses are at least three
// cells apart, so no forwarding is needed.
// Reset: counters, window and queue clear; the line store is not cleared
// (its first-rows contents never reach a result). An output stall only
// holds the queue; inputs keep flowing until the queue fills.
module cave_automaton_smoothing_pass
    import cas_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
    localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [GRID_W-1:0]  cfg_data,
    // input cells
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cell_alive,
    // smoothed cells
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CW-1:0]      out_row,
    output logic [CW-1:0]      out_col,
    output logic               new_alive,
    output logic               frame_done
);

    localparam int RW = 2 * CW + 2;

    // Config
    logic [CW-1:0]      side_m1_reg;
    logic [LIMIT_W-1:0] death_reg;
    logic [LIMIT_W-1:0] birth_reg;
    logic               grid_wr;

    // Raster position of the next input cell
    logic [CW-1:0]      row_reg;
    logic [CW-1:0]      col_reg;

    // Decision stage
    logic               s1_valid_reg;
    logic [CW-1:0]      s1_row_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_cell_reg;
    logic [1:0]         line_rd_reg;   // bit0 two rows up, bit1 one row up
    logic [1:0]         line_mem [MAX_SIDE];
    logic [8:0]         win_reg;
    logic [8:0]         win_next;

    logic               accept;
    logic               fifo_room;
    logic               center;
    logic [3:0]         nbr_cnt;
    logic               interior;
    logic               alive_a;
    logic               emit_a;
    logic               emit_b;
    logic               emit_c;
    logic               col_last;
    logic [CW-1:0]      row_m1;
    logic [CW-1:0]      col_m1;
    logic [RW-1:0]      res_a;
    logic [RW-1:0]      res_b;
    logic [RW-1:0]      res_c;
    logic [MAX_RESULTS-1:0][RW-1:0] push_data;
    logic [PUSH_W-1:0]  push_n;
    logic [RW-1:0]      fifo_out;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !fifo_room;
    assign grid_wr  = cfg_we && (cfg_index == CFG_GRID_SIZE);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_m1_reg <= CW'(side_m1_of(GRID_SIZE_RST, MAX_SIDE));
            death_reg   <= DEATH_LIMIT_RST;
            birth_reg   <= BIRTH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_SIZE:   side_m1_reg <= CW'(side_m1_of(cfg_data, MAX_SIDE));
                CFG_DEATH_LIMIT: death_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_BIRTH_LIMIT: birth_reg   <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (grid_wr)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == side_m1_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == side_m1_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_cell_reg <= cell_alive;
        end
    end

    // Line store: read at accept, shift the column down one row at the next edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= {s1_cell_reg, line_rd_reg[1]};
        end
    end

    // 3x3 window, newest column in the low bits
    assign win_next = {win_reg[5:0], s1_cell_reg, line_rd_reg[1], line_rd_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (grid_wr)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // Decision for the window center (row-1, col-1)
    always_comb
    begin
        nbr_cnt = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                nbr_cnt = nbr_cnt + 4'(win_next[i]);
            end
        end
    end

    assign center   = win_next[4];
    assign interior = (s1_row_reg > CW'(1)) && (s1_col_reg > CW'(1));
    assign col_last = (s1_col_reg == side_m1_reg);
    assign row_m1   = s1_row_reg - 1'b1;
    assign col_m1   = s1_col_reg - 1'b1;

    always_comb
    begin
        alive_a = center;
        if (interior)
        begin
            if (center && (nbr_cnt < death_reg))
            begin
                alive_a = 1'b0;
            end
            else if (nbr_cnt > birth_reg)
            begin
                alive_a = 1'b1;
            end
        end
    end

    assign emit_a = s1_valid_reg && (s1_row_reg != '0) && (s1_col_reg != '0);
    assign emit_b = s1_valid_reg && (s1_row_reg != '0) && col_last;
    assign emit_c = s1_valid_reg && (s1_row_reg == side_m1_reg);

    assign res_a = {row_m1, col_m1, alive_a, 1'b0};
    assign res_b = {row_m1, s1_col_reg, line_rd_reg[1], 1'b0};
    assign res_c = {s1_row_reg, s1_col_reg, s1_cell_reg, col_last};

    // Pack the emitted results in order
    always_comb
    begin
        push_data = '0;
        push_n    = '0;
        if (emit_a)
        begin
            push_data[push_n] = res_a;
            push_n = push_n + 1'b1;
        end
        if (emit_b)
        begin
            push_data[push_n] = res_b;
            push_n = push_n + 1'b1;
        end
        if (emit_c)
        begin
            push_data[push_n] = res_c;
            push_n = push_n + 1'b1;
        end
    end

    cas_out_fifo #(
        .W     (RW),
        .DEPTH (RES_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (push_data),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (fifo_out)
    );

    assign {out_row, out_col, new_alive, frame_done} = fifo_out;

endmodule

// ===== rtl/core/cas_port_checker.sv =====
`timescale 1ns / 1ps

module cas_port_checker
    import cas_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE,
    localparam int CW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1
)
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input logic [CW-1:0] out_row,
    input logic [CW-1:0] out_col,
    input logic          new_alive,
    input logic          frame_done
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({out_row, out_col, new_alive, frame_done}))
        else $error("stalled result changed");

    // Last result of a pass is the bottom-right corner.
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> out_row == out_col && out_row != '0)
        else $error("frame_done off the corner cell");

    // After a pass ends, the next result opens the grid at the origin.
    a_next_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_done |=>
            !out_valid || (out_row == '0 && out_col == '0))
        else $error("next pass does not start at the origin");

    // Output goes valid only after an input transaction has passed the decision stage and the queue.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a causing input");

endmodule

bind cave_automaton_smoothing_pass cas_port_checker #(.MAX_SIDE(MAX_SIDE)) u_port_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cas_pkg::*;

    localparam int SIDE_MAX      = DEFAULT_MAX_SIDE;
    localparam int SIDE_W        = $clog2(DEFAULT_MAX_SIDE);
    // cycles without any transaction on either channel before we give up
    localparam int IDLE_LIMIT    = 1000;
    // result passes the decision stage and the queue after the cell that completes it; pad a bit
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CELLS  = 160;
    localparam int HOLD_CYCLES   = 90;

    typedef struct packed {
        bit [SIDE_W-1:0] row;
        bit [SIDE_W-1:0] col;
        bit              alive;
        bit              done;
    } smoothed_cell_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IW-1:0]  cfg_index;
    logic [GRID_W-1:0]  cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               cell_alive;
    logic               out_valid;
    logic               out_stall;
    logic [SIDE_W-1:0]  out_row;
    logic [SIDE_W-1:0]  out_col;
    logic               new_alive;
    logic               frame_done;

    // raster cells waiting to be offered, and smoothed cells still owed
    bit             raster_cells[$];
    smoothed_cell_t smoothed_q[$];

    // shadow of the block: line stores, 3x3 window, raster position, registers
    bit                 two_up_row[SIDE_MAX];
    bit                 one_up_row[SIDE_MAX];
    bit [8:0]           moore_win;
    int                 row_pos;
    int                 col_pos;
    bit [GRID_W-1:0]    grid_sz;
    bit [LIMIT_W-1:0]   death_lim;
    bit [LIMIT_W-1:0]   birth_lim;

    int  send_idle_pct;
    int  stall_pct;
    int  hold_left;
    int  mismatches;
    int  quiet_cycles;
    bit  cell_taken;

    cave_automaton_smoothing_pass #(
        .MAX_SIDE (SIDE_MAX)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_alive (cell_alive),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .new_alive  (new_alive),
        .frame_done (frame_done)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int side_of(input bit [GRID_W-1:0] g);
        if (g < 3)
            return 3;
        if (g > SIDE_MAX)
            return SIDE_MAX;
        return int'(g);
    endfunction

    function automatic void owe_cell(input int row, input int col, input bit alive,
                                     input bit done);
        smoothed_cell_t s;
        s.row   = SIDE_W'(row);
        s.col   = SIDE_W'(col);
        s.alive = alive;
        s.done  = done;
        smoothed_q.insert(smoothed_q.size(), s);
    endfunction

    // One accepted raster cell: shift it into the line stores and the window,
    // then queue whatever cells its arrival completes, in emission order.
    function automatic void smooth_step(input bit cur_cell);
        int n;
        int r;
        int c;
        int er;
        int ec;
        int live;
        bit two_up;
        bit one_up;
        bit center;
        bit verdict;
        n = side_of(grid_sz);
        r = (row_pos >= n) ? n - 1 : row_pos;
        c = (col_pos >= n) ? n - 1 : col_pos;
        two_up = two_up_row[c];
        one_up = one_up_row[c];
        two_up_row[c] = one_up;
        one_up_row[c] = cur_cell;
        // newest column enters at the low end: bit0 two rows up, bit2 this row
        moore_win = {moore_win[5:0], cur_cell, one_up, two_up};

        // the cell up and to the left is now surrounded
        if (r >= 1 && c >= 1) begin
            center  = moore_win[4];
            verdict = center;
            er = r - 1;
            ec = c - 1;
            if (er >= 1 && ec >= 1 && er <= n - 2 && ec <= n - 2) begin
                live = $countones(moore_win) - center;
                if (center && live < death_lim)
                    verdict = 1'b0;
                else if (live > birth_lim)
                    verdict = 1'b1;
            end
            owe_cell(er, ec, verdict, 1'b0);
        end
        // right border cell of the row above passes through
        if (r >= 1 && c == n - 1)
            owe_cell(r - 1, c, one_up, 1'b0);
        // bottom row passes through as it arrives; its last cell ends the frame
        if (r == n - 1)
            owe_cell(r, c, cur_cell, c == n - 1);

        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Register write, one cycle of cfg_we. Only called with both channels
    // quiet, so the shadow registers can follow immediately.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[GRID_W-1:0];
        case (idx)
            CFG_GRID_SIZE:
            begin
                // new side restarts the raster; line stores keep their bits
                grid_sz   = value[GRID_W-1:0];
                row_pos   = 0;
                col_pos   = 0;
                moore_win = '0;
            end
            CFG_DEATH_LIMIT: death_lim = value[LIMIT_W-1:0];
            CFG_BIRTH_LIMIT: birth_lim = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input int death, input int birth);
        write_reg(CFG_DEATH_LIMIT, death);
        write_reg(CFG_BIRTH_LIMIT, birth);
    endtask

    // 0: free flowing, 1: sender gaps, 2: receiver stalls, 3: both
    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 56; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 56; end
            3:       begin send_idle_pct = 30; stall_pct = 30; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic push_pattern(input bit [8:0] pattern);
        for (int i = 0; i < 9; i++)
            raster_cells.insert(raster_cells.size(), pattern[i]);
    endtask

    task automatic push_cells(input int count, input int density);
        repeat (count)
            raster_cells.insert(raster_cells.size(), $urandom_range(99) < density);
    endtask

    // Wait out everything in flight. Cells in the top row complete nothing,
    // so the block may still be busy after the last owed cell arrives; the
    // settle cycles cover that before the next register write.
    task automatic drain();
        while (raster_cells.size() != 0 || in_valid || smoothed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Input driver: a new transaction goes out only when the previous one
    // was taken (or nothing was offered), so a stalled cell holds steady.
    always @(negedge clk)
    begin
        if (!in_valid || cell_taken) begin
            if (raster_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid   <= 1'b1;
                cell_alive <= raster_cells.pop_front();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output backpressure. A long hold lets the result queue fill while the
    // sender keeps offering, which should push in_stall up.
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: both channels sampled at the rising edge.
    always @(posedge clk)
    begin
        smoothed_cell_t want;
        bit             result_taken;
        cell_taken   = 1'b0;
        result_taken = 1'b0;
        if (rst_n) begin
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                result_taken = 1'b1;
                if (smoothed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected cell (%0d,%0d) alive=%b done=%b",
                                              out_row, out_col, new_alive, frame_done));
                end
                else begin
                    want = smoothed_q.pop_front();
                    if (out_row !== want.row)
                        report_mismatch($sformatf("out_row got %0d want %0d",
                                                  out_row, want.row));
                    if (out_col !== want.col)
                        report_mismatch($sformatf("out_col got %0d want %0d",
                                                  out_col, want.col));
                    if (new_alive !== want.alive)
                        report_mismatch($sformatf("new_alive at (%0d,%0d) got %b want %b",
                                                  want.row, want.col, new_alive, want.alive));
                    if (frame_done !== want.done)
                        report_mismatch($sformatf("frame_done at (%0d,%0d) got %b want %b",
                                                  want.row, want.col, frame_done, want.done));
                end
            end
            if (in_valid && in_stall === 1'b0) begin
                cell_taken = 1'b1;
                smooth_step(cell_alive);
            end
            if (cell_taken || result_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        int fed;
        int n;
        int cells;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_GRID_SIZE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        cell_alive    = 1'b0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        moore_win     = '0;
        row_pos       = 0;
        col_pos       = 0;
        grid_sz       = GRID_SIZE_RST;
        death_lim     = DEATH_LIMIT_RST;
        birth_lim     = BIRTH_LIMIT_RST;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: 3x3 grids, one interior cell each ---
        set_idling(0);
        // full neighborhood, no death, birth impossible: center stays alive
        write_reg(CFG_GRID_SIZE, 3);
        set_limits(0, 8);
        push_pattern(9'h1FF);
        drain();
        // side below minimum acts as 3; death limit above 8 kills a full house
        write_reg(CFG_GRID_SIZE, 0);
        set_limits(9, 4);
        push_pattern(9'h1FF);
        drain();
        // dead center in a full ring, top limits: no birth
        write_reg(CFG_GRID_SIZE, 2);
        set_limits(15, 15);
        push_pattern(9'b111101111);
        drain();

        // --- widest grid, partial pass; side above the store depth clamps ---
        set_idling(3);
        write_reg(CFG_GRID_SIZE, 255);
        set_limits(0, 0);
        push_cells(SIDE_MAX + 40, 50);
        drain();

        // --- random small grids, whole and partial passes ---
        fed   = 0;
        phase = 0;
        while (fed < RANDOM_CELLS) begin
            set_idling(phase % 4);
            if (phase == 0) begin
                write_reg(CFG_GRID_SIZE, 8);
            end
            else if ($urandom_range(2) != 0) begin
                if ($urandom_range(7) == 0)
                    write_reg(CFG_GRID_SIZE, $urandom_range(0, 2));
                else
                    write_reg(CFG_GRID_SIZE, $urandom_range(3, 9));
            end
            // otherwise the pass carries on with only the limits changed
            if ($urandom_range(3) != 0)
                set_limits($urandom_range(2, 6), $urandom_range(2, 6));
            else
                set_limits($urandom_range(0, 15), $urandom_range(0, 15));
            n = side_of(grid_sz);
            cells = n * n;
            if ($urandom_range(1) != 0)
                cells += $urandom_range(0, n * n - 1);
            if (phase == 0)
                hold_left = HOLD_CYCLES;
            push_cells(cells, $urandom_range(15, 85));
            drain();
            fed += cells;
            phase++;
        end

        if (smoothed_q.size() != 0)
            report_mismatch($sformatf("%0d smoothed cells never came out",
                                      smoothed_q.size()));
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cas_pkg.sv
rtl/core/cas_out_fifo.sv
rtl/core/cave_automaton_smoothing_pass.sv
rtl/core/cas_port_checker.sv
tb/testbench.sv
